/* hw/rtl/opr_pkg.sv */
// Shared types, constants and character helpers for the OBD reply decoder.
package opr_pkg;

  localparam int LINE_MAX_LEN_DEF = 255;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_PID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EOL_CHAR     = 2'd1;

  localparam logic [7:0] EOL_RESET   = 8'd13;
  localparam logic [7:0] CHAR_PROMPT = 8'h3E;
  localparam logic [7:0] CHAR_NUL    = 8'h00;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TOO_FEW     = 3'd1;
  localparam logic [2:0] ST_MISMATCH    = 3'd2;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
  localparam logic [2:0] ST_LINK_EMPTY  = 3'd4;

  localparam logic [2:0] MAX_PAIRS = 3'd6;
  localparam logic [7:0] ECHO_BIAS = 8'd64;

  // quotient estimates: (100*a*257)>>16 for /255, (w*655)>>16 for /100
  localparam logic [22:0] RECIP_255 = 23'd25700;
  localparam logic [25:0] RECIP_100 = 26'd655;

  localparam logic [15:0] PID_0104 = 16'h0104;
  localparam logic [15:0] PID_0105 = 16'h0105;
  localparam logic [15:0] PID_010B = 16'h010B;
  localparam logic [15:0] PID_010C = 16'h010C;
  localparam logic [15:0] PID_010D = 16'h010D;
  localparam logic [15:0] PID_010F = 16'h010F;
  localparam logic [15:0] PID_0110 = 16'h0110;
  localparam logic [15:0] PID_0111 = 16'h0111;
  localparam logic [15:0] PID_011F = 16'h011F;
  localparam logic [15:0] PID_0123 = 16'h0123;
  localparam logic [15:0] PID_0133 = 16'h0133;
  localparam logic [15:0] PID_0134 = 16'h0134;
  localparam logic [15:0] PID_0145 = 16'h0145;
  localparam logic [15:0] PID_0146 = 16'h0146;
  localparam logic [15:0] PID_0149 = 16'h0149;
  localparam logic [15:0] PID_014A = 16'h014A;
  localparam logic [15:0] PID_014C = 16'h014C;

  typedef struct packed {
    logic       link_empty;
    logic [2:0] pairs;
    logic [7:0] len;
    logic [7:0] echo0;
    logic [7:0] echo1;
    logic [7:0] data_a;
    logic [7:0] data_b;
  } line_rec_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    hex_val = v[3:0];
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

/* hw/rtl/obd_pid_response_decoder.sv */
// Top level of the OBD-II mode 01 reply decoder: config registers, front, queue, back.
//
//  channel  direction  handshake             payload
//  in_      request    in_valid / in_stall   in_rx_byte, in_link_error
//  out_     result     out_valid / out_stall out_status, out_decoded_value,
//                                            out_field_count, out_line_length
//  cfg_     write      cfg_valid / cfg_ready cfg_index, cfg_wdata
//
// One request per cycle unless stalled; front end updates line state in the accept cycle.
// A closing request (end of line or link error) passes queue, stage 1 and result register.
// A two-entry line queue lets the front keep taking requests while the back stalls.
// in_stall rises only when that queue is full; cfg_ready is always high.
// Synchronous active-low reset clears line state, queue and pipeline; eol_char resets to 13.
module obd_pid_response_decoder #(
  parameter int LINE_MAX_LEN = opr_pkg::LINE_MAX_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_rx_byte,
  input  logic                           in_link_error,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_status,
  output logic signed [20:0]             out_decoded_value,
  output logic [2:0]                     out_field_count,
  output logic [7:0]                     out_line_length,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [opr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [opr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [15:0] expected_pid_r, expected_pid_nxt;
  logic [7:0]  eol_char_r, eol_char_nxt;

  logic               accept;
  logic               push;
  opr_pkg::line_rec_t push_rec;
  logic               q_full, q_vld, q_pop;
  opr_pkg::line_rec_t q_head;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = q_full;

  always_comb begin
    expected_pid_nxt = expected_pid_r;
    eol_char_nxt     = eol_char_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        opr_pkg::REG_EXPECTED_PID: expected_pid_nxt = cfg_wdata;
        opr_pkg::REG_EOL_CHAR:     eol_char_nxt = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_pid_r <= 16'd0;
      eol_char_r     <= opr_pkg::EOL_RESET;
    end else begin
      expected_pid_r <= expected_pid_nxt;
      eol_char_r     <= eol_char_nxt;
    end
  end

  opr_front #(
    .LINE_MAX_LEN(LINE_MAX_LEN)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .rx_byte    (in_rx_byte),
    .link_error (in_link_error),
    .eol_char   (eol_char_r),
    .push       (push),
    .rec        (push_rec)
  );

  opr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_vld),
    .head      (q_head)
  );

  opr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_vld             (q_vld),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .expected_pid      (expected_pid_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_decoded_value (out_decoded_value),
    .out_field_count   (out_field_count),
    .out_line_length   (out_line_length)
  );

  a_value_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != opr_pkg::ST_OK |-> out_decoded_value == 21'sd0)
    else $error("decoded value set on a failed reply");

  a_link_empty_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == opr_pkg::ST_LINK_EMPTY |->
      out_field_count == 3'd0 && out_line_length == 8'd0)
    else $error("empty link error carries line data");

  a_too_few: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_field_count < 3'd2 && out_status != opr_pkg::ST_LINK_EMPTY |->
      out_status == opr_pkg::ST_TOO_FEW)
    else $error("short reply not reported as too few fields");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("line closed into a full queue");

endmodule

/* hw/rtl/opr_front.sv */
// Front end: filters received bytes, parses hex pairs and closes reply lines.
module opr_front #(
  parameter int LINE_MAX_LEN = opr_pkg::LINE_MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  input  logic              link_error,
  input  logic [7:0]        eol_char,
  output logic              push,
  output opr_pkg::line_rec_t rec
);

  localparam int CNT_W = $clog2(LINE_MAX_LEN + 1);
  localparam int EXT_W = (CNT_W > 8) ? CNT_W : 8;

  logic             in_line_r, in_line_nxt;
  logic [CNT_W-1:0] line_cnt_r, line_cnt_nxt;
  logic [3:0]       acc_r, acc_nxt;
  logic             digit_r, digit_nxt;
  logic [2:0]       pairs_r, pairs_nxt;
  logic             stopped_r, stopped_nxt;
  logic [7:0]       echo0_r, echo0_nxt, echo1_r, echo1_nxt;
  logic [7:0]       data_a_r, data_a_nxt, data_b_r, data_b_nxt;

  logic [EXT_W-1:0] cnt_ext;
  logic             c_hex;
  logic [3:0]       c_val;
  logic [2:0]       slot;
  logic [7:0]       slot_byte;
  logic             slot_wr;
  logic             close_line;
  logic             keep_char;

  assign cnt_ext = EXT_W'(line_cnt_r);
  assign c_hex   = opr_pkg::is_hex(rx_byte);
  assign c_val   = opr_pkg::hex_val(rx_byte);

  always_comb begin
    close_line = 1'b0;
    keep_char  = 1'b0;
    if (accept) begin
      if (link_error) begin
        close_line = 1'b1;
      end else if (rx_byte != opr_pkg::CHAR_NUL) begin
        if (!in_line_r) begin
          keep_char = (rx_byte != eol_char) && (rx_byte != opr_pkg::CHAR_PROMPT);
        end else if (rx_byte == eol_char) begin
          close_line = 1'b1;
        end else begin
          keep_char = 1'b1;
        end
      end
    end
  end

  always_comb begin
    rec.link_empty = !in_line_r;
    rec.pairs      = pairs_r;
    rec.len        = (cnt_ext > EXT_W'(255)) ? 8'hFF : cnt_ext[7:0];
    rec.echo0      = echo0_r;
    rec.echo1      = echo1_r;
    rec.data_a     = data_a_r;
    rec.data_b     = data_b_r;
  end

  assign push = close_line;

  always_comb begin
    in_line_nxt  = in_line_r;
    line_cnt_nxt = line_cnt_r;
    acc_nxt      = acc_r;
    digit_nxt    = digit_r;
    pairs_nxt    = pairs_r;
    stopped_nxt  = stopped_r;
    echo0_nxt    = echo0_r;
    echo1_nxt    = echo1_r;
    data_a_nxt   = data_a_r;
    data_b_nxt   = data_b_r;
    slot         = 3'd0;
    slot_byte    = 8'd0;
    slot_wr      = 1'b0;
    if (close_line) begin
      in_line_nxt  = 1'b0;
      line_cnt_nxt = '0;
      acc_nxt      = 4'd0;
      digit_nxt    = 1'b0;
      pairs_nxt    = 3'd0;
      stopped_nxt  = 1'b0;
      echo0_nxt    = 8'd0;
      echo1_nxt    = 8'd0;
      data_a_nxt   = 8'd0;
      data_b_nxt   = 8'd0;
    end else if (keep_char && line_cnt_r < CNT_W'(LINE_MAX_LEN)) begin
      line_cnt_nxt = line_cnt_r + 1'b1;
      in_line_nxt  = 1'b1;
      if (!stopped_r) begin
        if (c_hex) begin
          if (digit_r) begin
            slot      = pairs_r - 3'd1;
            slot_byte = {acc_r, c_val};
            slot_wr   = 1'b1;
            digit_nxt = 1'b0;
          end else if (pairs_r < opr_pkg::MAX_PAIRS) begin
            slot      = pairs_r;
            slot_byte = {4'd0, c_val};
            slot_wr   = 1'b1;
            acc_nxt   = c_val;
            pairs_nxt = pairs_r + 3'd1;
            digit_nxt = 1'b1;
          end else begin
            stopped_nxt = 1'b1;
          end
        end else if (opr_pkg::is_blank(rx_byte)) begin
          digit_nxt = 1'b0;
        end else begin
          digit_nxt   = 1'b0;
          stopped_nxt = 1'b1;
        end
      end
      if (slot_wr) begin
        case (slot)
          3'd0: echo0_nxt = slot_byte;
          3'd1: echo1_nxt = slot_byte;
          3'd2: data_a_nxt = slot_byte;
          3'd3: data_b_nxt = slot_byte;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_line_r  <= 1'b0;
      line_cnt_r <= '0;
      acc_r      <= 4'd0;
      digit_r    <= 1'b0;
      pairs_r    <= 3'd0;
      stopped_r  <= 1'b0;
      echo0_r    <= 8'd0;
      echo1_r    <= 8'd0;
      data_a_r   <= 8'd0;
      data_b_r   <= 8'd0;
    end else begin
      in_line_r  <= in_line_nxt;
      line_cnt_r <= line_cnt_nxt;
      acc_r      <= acc_nxt;
      digit_r    <= digit_nxt;
      pairs_r    <= pairs_nxt;
      stopped_r  <= stopped_nxt;
      echo0_r    <= echo0_nxt;
      echo1_r    <= echo1_nxt;
      data_a_r   <= data_a_nxt;
      data_b_r   <= data_b_nxt;
    end
  end

endmodule

/* hw/rtl/opr_queue.sv */
// Two-entry queue of closed reply lines between front and back end.
module opr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  opr_pkg::line_rec_t push_rec,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output opr_pkg::line_rec_t head
);

  opr_pkg::line_rec_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* hw/rtl/opr_back.sv */
// Back end: echo check, PID formula in two stages and the result register.
module opr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_vld,
  input  opr_pkg::line_rec_t q_head,
  output logic               q_pop,
  input  logic [15:0]        expected_pid,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic signed [20:0] out_decoded_value,
  output logic [2:0]         out_field_count,
  output logic [7:0]         out_line_length
);

  typedef struct packed {
    logic       link_empty;
    logic [2:0] pairs;
    logic [7:0] len;
    logic       echo_ok;
    logic [7:0] data_a;
    logic [7:0] data_b;
    logic [6:0] q255;
    logic [9:0] q100;
  } mid_t;

  logic s1_vld_r, s1_vld_nxt;
  mid_t s1_r, s1_nxt;
  logic out_vld_r, out_vld_nxt;
  logic [2:0]         status_r, status_nxt;
  logic signed [20:0] value_r, value_nxt;
  logic [2:0]         pairs_r;
  logic [7:0]         len_r;

  logic out_free, s1_free, s1_move;
  logic [7:0]  echo_hi;
  logic [22:0] p255;
  logic [25:0] p100;
  logic [15:0] w_in;

  logic [15:0] w;
  logic [14:0] x, t255;
  logic [16:0] t100, r100;
  logic [6:0]  div255;
  logic [9:0]  div100;
  logic        known;
  logic signed [20:0] formula;

  assign out_free = !out_vld_r || !out_stall;
  assign s1_move  = s1_vld_r && out_free;
  assign s1_free  = !s1_vld_r || out_free;
  assign q_pop    = q_vld && s1_free;

  // stage 1: echo compare and reciprocal products
  always_comb begin
    echo_hi = q_head.echo0 - opr_pkg::ECHO_BIAS;
    w_in    = {q_head.data_a, q_head.data_b};
    p255    = 23'(q_head.data_a) * opr_pkg::RECIP_255;
    p100    = 26'(w_in) * opr_pkg::RECIP_100;
    s1_nxt.link_empty = q_head.link_empty;
    s1_nxt.pairs      = q_head.pairs;
    s1_nxt.len        = q_head.len;
    s1_nxt.echo_ok    = (q_head.echo0 >= opr_pkg::ECHO_BIAS) &&
                        ({echo_hi, q_head.echo1} == expected_pid);
    s1_nxt.data_a     = q_head.data_a;
    s1_nxt.data_b     = q_head.data_b;
    s1_nxt.q255       = p255[22:16];
    s1_nxt.q100       = p100[25:16];
    s1_vld_nxt        = q_pop ? 1'b1 : (s1_move ? 1'b0 : s1_vld_r);
  end

  // stage 2: quotient correction, formula select, status
  always_comb begin
    w      = {s1_r.data_a, s1_r.data_b};
    x      = 15'(s1_r.data_a) * 15'd100;
    t255   = 15'(s1_r.q255) * 15'd255;
    div255 = s1_r.q255 + {6'd0, ((x - t255) >= 15'd255)};
    t100   = 17'(s1_r.q100) * 17'd100;
    r100   = 17'(w) - t100;
    div100 = s1_r.q100 + {9'd0, (r100 >= 17'd100)};
    known   = 1'b1;
    formula = 21'sd0;
    case (expected_pid)
      opr_pkg::PID_0104, opr_pkg::PID_0111, opr_pkg::PID_0145, opr_pkg::PID_0149,
      opr_pkg::PID_014A, opr_pkg::PID_014C: formula = 21'(div255);
      opr_pkg::PID_0105, opr_pkg::PID_010F, opr_pkg::PID_0146:
        formula = $signed(21'(s1_r.data_a)) - 21'sd40;
      opr_pkg::PID_010B, opr_pkg::PID_010D, opr_pkg::PID_0133:
        formula = 21'(s1_r.data_a);
      opr_pkg::PID_010C: formula = 21'(w[15:2]);
      opr_pkg::PID_0110: formula = 21'(div100);
      opr_pkg::PID_011F: formula = 21'(w);
      opr_pkg::PID_0123: formula = 21'(20'(w) * 20'd10);
      opr_pkg::PID_0134: formula = 21'(w[15]);
      default: known = 1'b0;
    endcase
    value_nxt = 21'sd0;
    if (s1_r.link_empty) begin
      status_nxt = opr_pkg::ST_LINK_EMPTY;
    end else if (s1_r.pairs < 3'd2) begin
      status_nxt = opr_pkg::ST_TOO_FEW;
    end else if (!s1_r.echo_ok) begin
      status_nxt = opr_pkg::ST_MISMATCH;
    end else if (known) begin
      status_nxt = opr_pkg::ST_OK;
      value_nxt  = formula;
    end else begin
      status_nxt = opr_pkg::ST_UNSUPPORTED;
    end
    out_vld_nxt = s1_move ? 1'b1 : (out_free ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_r <= s1_nxt;
    end
    if (s1_move) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
      pairs_r  <= s1_r.pairs;
      len_r    <= s1_r.len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_status        = status_r;
  assign out_decoded_value = value_r;
  assign out_field_count   = pairs_r;
  assign out_line_length   = len_r;

endmodule

/* bench/obd_pid_response_decoder_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for the OBD-II reply decoder: a directed table, then random adapter replies.
module obd_pid_response_decoder_test;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int REQUEST_COUNT = 1900;
  localparam int SETTLE_CYCLES = 8;
  localparam int PLAN_LEN      = 32;
  localparam logic [15:0] PID_VIN = 16'h0902;

  localparam logic [15:0] KNOWN_PIDS [17] = '{
    opr_pkg::PID_0104, opr_pkg::PID_0105, opr_pkg::PID_010B, opr_pkg::PID_010C,
    opr_pkg::PID_010D, opr_pkg::PID_010F, opr_pkg::PID_0110, opr_pkg::PID_0111,
    opr_pkg::PID_011F, opr_pkg::PID_0123, opr_pkg::PID_0133, opr_pkg::PID_0134,
    opr_pkg::PID_0145, opr_pkg::PID_0146, opr_pkg::PID_0149, opr_pkg::PID_014A,
    opr_pkg::PID_014C
  };

  typedef struct packed {
    logic [2:0]         status;
    logic signed [20:0] value;
    logic [2:0]         fields;
    logic [7:0]         length;
  } reply_t;

  typedef enum logic { ROW_REQUEST, ROW_SETUP } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  ch;
    logic        err;
    logic [15:0] pid;
    logic        typed;
    reply_t      want;
  } plan_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [7:0]                     in_rx_byte = 8'd0;
  logic                           in_link_error = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [2:0]                     out_status;
  logic signed [20:0]             out_decoded_value;
  logic [2:0]                     out_field_count;
  logic [7:0]                     out_line_length;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [opr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [opr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  obd_pid_response_decoder i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  plan_row_t plan_rows [PLAN_LEN] = '{
    '{ROW_REQUEST, 8'h00, 1'b1, 16'h0000, 1'b1,
      '{opr_pkg::ST_LINK_EMPTY, 21'sd0, 3'd0, 8'd0}},
    '{ROW_SETUP, opr_pkg::EOL_RESET, 1'b0, opr_pkg::PID_010C, 1'b0, '0},
    '{ROW_REQUEST, opr_pkg::CHAR_PROMPT, 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, opr_pkg::EOL_RESET, 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, "4", 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, "1", 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, "0", 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, "C", 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, "F", 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, "f", 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, opr_pkg::EOL_RESET, 1'b0, 16'h0000, 1'b1,
      '{opr_pkg::ST_OK, 21'sd16320, 3'd3, 8'd6}},
    '{ROW_REQUEST, "4", 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, opr_pkg::CHAR_NUL, 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, 8'h55, 1'b1, 16'h0000, 1'b1,
      '{opr_pkg::ST_TOO_FEW, 21'sd0, 3'd1, 8'd1}},
    '{ROW_REQUEST, "Z", 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, opr_pkg::EOL_RESET, 1'b0, 16'h0000, 1'b1,
      '{opr_pkg::ST_TOO_FEW, 21'sd0, 3'd0, 8'd1}},
    '{ROW_SETUP, opr_pkg::CHAR_NUL, 1'b0, opr_pkg::PID_0123, 1'b0, '0},
    '{ROW_REQUEST, "4", 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, "1", 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, "2", 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, "3", 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, "F", 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, "F", 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, "F", 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, "F", 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, 8'hA5, 1'b1, 16'h0000, 1'b1,
      '{opr_pkg::ST_OK, 21'sd655350, 3'd4, 8'd8}},
    '{ROW_SETUP, 8'hFF, 1'b0, opr_pkg::PID_0105, 1'b0, '0},
    '{ROW_REQUEST, "4", 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, "1", 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, "0", 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, "5", 1'b0, 16'h0000, 1'b0, '0},
    '{ROW_REQUEST, 8'hFF, 1'b0, 16'h0000, 1'b1,
      '{opr_pkg::ST_OK, -21'sd40, 3'd2, 8'd4}}
  };

  logic [15:0] pid_reg;
  logic [7:0]  eol_reg;
  logic        in_line;
  logic [7:0]  kept;
  logic [7:0]  acc;
  logic [1:0]  ndig;
  logic [2:0]  npairs;
  logic        stopped;
  logic [7:0]  echo_hi;
  logic [7:0]  echo_lo;
  logic [7:0]  byte_a;
  logic [7:0]  byte_b;

  reply_t awaited_replies [$];
  int     fault_count = 0;
  int     requests_sent = 0;
  int     cycle_count = 0;
  bit     calm = 1'b0;
  bit     long_done = 1'b0;

  function automatic void clear_line();
    in_line = 1'b0;
    kept    = 8'd0;
    acc     = 8'd0;
    ndig    = 2'd0;
    npairs  = 3'd0;
    stopped = 1'b0;
    echo_hi = 8'd0;
    echo_lo = 8'd0;
    byte_a  = 8'd0;
    byte_b  = 8'd0;
  endfunction

  function automatic void store_pair(input logic [2:0] slot, input logic [7:0] v);
    case (slot)
      3'd0: echo_hi = v;
      3'd1: echo_lo = v;
      3'd2: byte_a = v;
      3'd3: byte_b = v;
      default: ;
    endcase
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    int h;
    if (stopped) return;
    h = -1;
    if (c >= "0" && c <= "9") h = int'(c - "0");
    else if (c >= "a" && c <= "f") h = int'(c - "a") + 10;
    else if (c >= "A" && c <= "F") h = int'(c - "A") + 10;
    if (h >= 0) begin
      if (ndig == 2'd1) begin
        acc = {acc[3:0], h[3:0]};
        store_pair(npairs - 3'd1, acc);
        ndig = 2'd0;
      end else if (npairs < opr_pkg::MAX_PAIRS) begin
        acc = 8'(h);
        npairs++;
        store_pair(npairs - 3'd1, acc);
        ndig = 2'd1;
      end else begin
        stopped = 1'b1;
      end
    end else begin
      ndig = 2'd0;
      if (!(c == 8'd32 || (c >= 8'd9 && c <= 8'd13))) stopped = 1'b1;
    end
  endfunction

  function automatic int pid_formula(input logic [15:0] pid, input int a, input int b,
                                     output bit known);
    int w;
    w = 256 * a + b;
    known = 1'b1;
    case (pid)
      opr_pkg::PID_0104, opr_pkg::PID_0111, opr_pkg::PID_0145, opr_pkg::PID_0149,
      opr_pkg::PID_014A, opr_pkg::PID_014C: return 100 * a / 255;
      opr_pkg::PID_0105, opr_pkg::PID_010F, opr_pkg::PID_0146: return a - 40;
      opr_pkg::PID_010B, opr_pkg::PID_010D, opr_pkg::PID_0133: return a;
      opr_pkg::PID_010C: return w / 4;
      opr_pkg::PID_0110: return w / 100;
      opr_pkg::PID_011F: return w;
      opr_pkg::PID_0123: return 10 * w;
      opr_pkg::PID_0134: return 2 * w / 65536;
      default: begin
        known = 1'b0;
        return 0;
      end
    endcase
  endfunction

  function automatic reply_t close_line();
    reply_t      r;
    logic [31:0] echo;
    bit          known;
    int          val;
    r = '0;
    val = 0;
    if (npairs < 3'd2) begin
      r.status = opr_pkg::ST_TOO_FEW;
    end else begin
      echo = ({24'd0, echo_hi} - {24'd0, opr_pkg::ECHO_BIAS}) * 32'd256 + {24'd0, echo_lo};
      if (echo != {16'd0, pid_reg}) begin
        r.status = opr_pkg::ST_MISMATCH;
      end else begin
        val = pid_formula(pid_reg, int'(byte_a), int'(byte_b), known);
        r.status = known ? opr_pkg::ST_OK : opr_pkg::ST_UNSUPPORTED;
      end
    end
    r.value  = val[20:0];
    r.fields = npairs;
    r.length = kept;
    clear_line();
    return r;
  endfunction

  function automatic bit predict_reply(input logic [7:0] ch, input logic err,
                                       output reply_t r);
    r = '0;
    if (err) begin
      if (in_line) begin
        r = close_line();
      end else begin
        clear_line();
        r.status = opr_pkg::ST_LINK_EMPTY;
      end
      return 1'b1;
    end
    if (ch == opr_pkg::CHAR_NUL) return 1'b0;
    if (!in_line) begin
      if (ch == eol_reg || ch == opr_pkg::CHAR_PROMPT) return 1'b0;
    end else if (ch == eol_reg) begin
      r = close_line();
      return 1'b1;
    end
    if (kept < opr_pkg::LINE_MAX_LEN_DEF) begin
      kept++;
      in_line = 1'b1;
      parse_char(ch);
    end
    return 1'b0;
  endfunction

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] nib, input bit lower);
    if (nib < 4'd10) return "0" + nib;
    return (lower ? "a" : "A") + nib - 8'd10;
  endfunction

  task automatic send_request(input logic [7:0] ch, input logic err, input bit typed = 1'b0,
                              input reply_t want = '0);
    int     gap;
    reply_t r;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_rx_byte    <= ch;
    in_link_error <= err;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    if (predict_reply(ch, err, r) || typed) awaited_replies.push_back(typed ? want : r);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] pid, input logic [7:0] eol);
    cfg_valid <= 1'b1;
    cfg_index <= opr_pkg::REG_EXPECTED_PID;
    cfg_wdata <= pid;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pid_reg = pid;
    cfg_index <= opr_pkg::REG_EOL_CHAR;
    cfg_wdata <= {8'($urandom), eol};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    eol_reg = eol;
    cfg_valid <= 1'b0;
  endtask

  task automatic change_setup();
    logic [15:0] pid;
    logic [7:0]  eol;
    case ($urandom_range(0, 9))
      0: pid = 16'h0000;
      1: pid = 16'hFFFF;
      2: pid = PID_VIN;
      3: pid = 16'($urandom);
      default: pid = KNOWN_PIDS[$urandom_range(0, 16)];
    endcase
    case ($urandom_range(0, 9))
      6: eol = 8'h0A;
      7: eol = opr_pkg::CHAR_NUL;
      8: eol = 8'hFF;
      9: eol = 8'($urandom);
      default: eol = opr_pkg::EOL_RESET;
    endcase
    settle();
    write_regs(pid, eol);
  endtask

  task automatic send_reply_line();
    logic [7:0] text [$];
    logic [7:0] pairs [$];
    int         kind;
    int         n;
    bit         single;
    kind = $urandom_range(1, 100);
    if (kind == 100 || (!long_done && requests_sent > 900)) begin
      long_done = 1'b1;
      n = $urandom_range(250, 300);
      repeat (n) begin
        text.push_back($urandom_range(0, 16) == 16 ? 8'h20 :
                       nibble_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      end
    end else if (kind < 20) begin
      n = $urandom_range(0, 12);
      repeat (n) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 7))
        0: text.push_back(opr_pkg::CHAR_PROMPT);
        1: text.push_back(eol_reg);
        2: text.push_back(opr_pkg::CHAR_NUL);
        3: text.push_back(8'h20);
        default: ;
      endcase
      pairs.push_back($urandom_range(0, 9) == 0 ? 8'($urandom) :
                      pid_reg[15:8] + opr_pkg::ECHO_BIAS);
      pairs.push_back($urandom_range(0, 9) == 0 ? 8'($urandom) : pid_reg[7:0]);
      n = $urandom_range(0, 9) == 0 ? 6 : $urandom_range(0, 4);
      repeat (n) pairs.push_back(8'($urandom));
      case ($urandom_range(0, 19))
        0: pairs.delete();
        1: pairs = pairs[0:0];
        default: ;
      endcase
      foreach (pairs[i]) begin
        single = $urandom_range(0, 9) == 0;
        if (!single) text.push_back(nibble_char(pairs[i][7:4], 1'($urandom_range(0, 1))));
        text.push_back(nibble_char(pairs[i][3:0], 1'($urandom_range(0, 1))));
        if ($urandom_range(0, 19) == 0) text.push_back(opr_pkg::CHAR_NUL);
        case ($urandom_range(0, 5))
          0: if (single) text.push_back(8'h20);
          4: text.push_back(8'h09);
          5: text.push_back(8'($urandom_range(9, 13)));
          default: text.push_back(8'h20);
        endcase
      end
      if ($urandom_range(0, 7) == 0) begin
        text.push_back(8'($urandom_range(33, 126)));
        text.push_back("7");
        text.push_back("F");
      end
    end
    foreach (text[i]) send_request(text[i], 1'b0);
    if (eol_reg == opr_pkg::CHAR_NUL || $urandom_range(0, 9) == 0) begin
      send_request(8'($urandom), 1'b1);
    end else begin
      send_request(eol_reg, 1'b0);
    end
    if ($urandom_range(0, 19) == 0) send_request(8'($urandom), 1'b1);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    reply_t got;
    reply_t want;
    int     gap;
    @(posedge rst_n);
    forever begin
      gap = draw_wait();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = {out_status, out_decoded_value, out_field_count, out_line_length};
      if (awaited_replies.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected reply, expected none, got status %0d value %0d %s",
                 $time, got.status, got.value,
                 $sformatf("fields %0d length %0d", got.fields, got.length));
      end else begin
        want = awaited_replies.pop_front();
        if (got !== want) begin
          fault_count++;
          $display("%0t: reply mismatch, expected status %0d value %0d fields %0d length %0d",
                   $time, want.status, want.value, want.fields, want.length);
          $display("%0t: got status %0d value %0d fields %0d length %0d",
                   $time, got.status, got.value, got.fields, got.length);
        end
      end
    end
  end

  initial begin
    int lines_left;
    pid_reg = 16'h0000;
    eol_reg = opr_pkg::EOL_RESET;
    clear_line();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (plan_rows[i]) begin
      if (plan_rows[i].kind == ROW_SETUP) begin
        settle();
        write_regs(plan_rows[i].pid, plan_rows[i].ch);
      end else begin
        send_request(plan_rows[i].ch, plan_rows[i].err, plan_rows[i].typed, plan_rows[i].want);
      end
    end
    lines_left = 0;
    while (requests_sent < REQUEST_COUNT) begin
      if (lines_left == 0) begin
        change_setup();
        lines_left = $urandom_range(8, 30);
      end
      if ($urandom_range(0, 29) == 0) calm = !calm;
      send_reply_line();
      lines_left--;
    end
    settle();
    if (fault_count == 0 && awaited_replies.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
